// ----- hdl/bbd_pkg.sv -----
// Shared constants and types for the bilinear demosaic core.
`default_nettype none
package bbd_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int SAMPLE_BITS = 16;
   localparam int WIDTH_BITS  = 13;
   localparam int HEIGHT_BITS = 16;
   localparam int ROW_BITS    = HEIGHT_BITS + 1;
   localparam int SUM_BITS    = SAMPLE_BITS + 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   // index 0 top row, 1 middle row, 2 bottom row
   typedef sample_type [2:0] column_type;
   typedef logic [SUM_BITS-1:0] sum_type;

   typedef enum logic [0:0] {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = HEIGHT_BITS'(1);

   // edge and phase info travelling with one beat into the window stage
   typedef struct packed {
      logic emit;
      logic left_edge;
      logic right_edge;
      logic top_edge;
      logic bottom_edge;
      logic odd_row;
      logic odd_col;
      logic row_end;
      logic frame_end;
   } site_info_type;

endpackage
`default_nettype wire

// ----- hdl/bbd_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module bbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/bayer_bilinear_demosaic_core.sv -----
// Top level of the RGGB bilinear demosaic core: counters, line store, window, output.
//
// Usage: raw Bayer samples enter on the req_ stream in raster order (tuser 0),
// one beat per clock. Drain beats (tuser 1) flush the frame once all raw
// pixels are in; width+1 of them complete it. Drains sent early are taken and
// dropped; raw beats sent after the frame is complete act as drains.
// Each RGB site leaves on the rsp_ stream; tlast marks the last pixel of a row
// and tuser the last pixel of the frame. The result for site k is caused by
// input beat k+width+1 and reaches rsp_ through the window stage and the output register.
// Throughput is one beat per clock unless rsp_ stalls, set by the single-port-read
// line store (one read and one write per beat) and the one-stage window datapath.
// The output register and window stage form a two-deep pipe: when rsp_tready
// is low, beats are still taken until the window stage holds a beat too.
// Frame width and height are set over the csr_ port while the core is idle;
// a write restarts the frame. Reset clears the counters and window, sets the
// width to 4096 and height to 1; the line store needs no clearing pass.
`default_nettype none
module bayer_bilinear_demosaic_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [bbd_pkg::SAMPLE_BITS-1:0]     req_tdata,  // raw_sample
   input  wire logic                                req_tuser,  // cmd
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [3*bbd_pkg::SAMPLE_BITS-1:0]   rsp_tdata,  // red, green, blue
   output logic                                     rsp_tlast,  // row_end
   output logic                                     rsp_tuser,  // frame_end
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [bbd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [bbd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [bbd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                     csr_pready
);
   import bbd_pkg::*;

   // configuration
   logic [WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic                   cfg_write;
   reg_index_type          csr_index;
   logic [WIDTH_BITS-1:0]  w_eff;
   logic [HEIGHT_BITS-1:0] h_eff;

   // position counters
   logic [COL_BITS-1:0]    in_column_ff, in_column_in;
   logic [ROW_BITS-1:0]    in_row_ff, in_row_in;
   logic [COL_BITS-1:0]    out_column_ff, out_column_in;
   logic [HEIGHT_BITS-1:0] out_row_ff, out_row_in;

   // intake decode
   logic          accept, pass, drain, frame_done;
   logic          in_wrap, out_wrap;
   site_info_type site;

   // window stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_go, out_free;
   site_info_type       s1_site_ff;
   sample_type          s1_sample_ff;
   logic [COL_BITS-1:0] s1_col_ff;
   logic                fwd_ff, fwd_in;
   sample_type          fwd_near_ff, fwd_far_ff;
   logic [2*SAMPLE_BITS-1:0] ram_rd_data;
   sample_type          near_eff, far_eff;
   column_type          win_ff [3];
   column_type          win_in [3];
   column_type          col_l, col_c, col_r;

   // interpolation
   sample_type up_l, up_c, up_r, dn_l, dn_c, dn_r;
   sum_type    cross_sum, diag_sum, horiz_sum, vert_sum;
   sample_type cross_avg, diag_avg, horiz_avg, vert_avg;
   sample_type red_c, green_c, blue_c;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type red_ff, green_ff, blue_ff;
   logic       row_end_ff, frame_end_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (cfg_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_pwdata[WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (frame_width_ff > WIDTH_BITS'(MAX_WIDTH)) begin
         w_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      h_eff = (frame_height_ff == '0) ? HEIGHT_BITS'(1) : frame_height_ff;
   end

   // ---------------- handshake ----------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // ---------------- intake decode and counters ----------------
   always_comb begin
      drain      = (cmd_type'(req_tuser) == CMD_DRAIN);
      frame_done = in_row_ff >= ROW_BITS'(h_eff);
      pass       = accept && !(drain && !frame_done);

      site.emit        = (in_row_ff >= ROW_BITS'(2)) ||
                         (in_row_ff == ROW_BITS'(1) && in_column_ff != '0);
      site.left_edge   = (out_column_ff == '0);
      site.right_edge  = (WIDTH_BITS'(out_column_ff) + WIDTH_BITS'(1)) >= w_eff;
      site.top_edge    = (out_row_ff == '0);
      site.bottom_edge = (ROW_BITS'(out_row_ff) + ROW_BITS'(1)) >= ROW_BITS'(h_eff);
      site.odd_row     = out_row_ff[0];
      site.odd_col     = out_column_ff[0];
      site.row_end     = site.right_edge;
      site.frame_end   = site.right_edge && site.bottom_edge;

      in_wrap  = (WIDTH_BITS'(in_column_ff) + WIDTH_BITS'(1)) >= w_eff;
      out_wrap = site.right_edge;

      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;

      if (cfg_write || (pass && site.emit && site.frame_end)) begin
         in_column_in  = '0;
         in_row_in     = '0;
         out_column_in = '0;
         out_row_in    = '0;
      end else if (pass) begin
         if (in_wrap) begin
            in_column_in = '0;
            in_row_in    = in_row_ff + ROW_BITS'(1);
         end else begin
            in_column_in = in_column_ff + COL_BITS'(1);
         end
         if (site.emit) begin
            if (out_wrap) begin
               out_column_in = '0;
               out_row_in    = out_row_ff + HEIGHT_BITS'(1);
            end else begin
               out_column_in = out_column_ff + COL_BITS'(1);
            end
         end
      end
   end

   // ---------------- line store ----------------
   // upper half holds the latest row, lower half the row before it
   bbd_ram #(
      .WIDTH (2*SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_sample_ff, near_eff}),
      .rd_en   (pass),
      .rd_addr (in_column_ff),
      .rd_data (ram_rd_data)
   );

   // the write of the beat leaving the window stage lands on the edge that reads
   // the next beat; on an address match take the written values instead
   assign near_eff = fwd_ff ? fwd_near_ff : ram_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign far_eff  = fwd_ff ? fwd_far_ff  : ram_rd_data[SAMPLE_BITS-1:0];
   assign fwd_in   = pass ? (s1_go && s1_col_ff == in_column_ff) : (fwd_ff && !s1_go);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pass) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- window ----------------
   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = {s1_sample_ff, near_eff, far_eff};

      col_l = s1_site_ff.left_edge  ? win_in[1] : win_in[0];
      col_c = win_in[1];
      col_r = s1_site_ff.right_edge ? win_in[1] : win_in[2];

      up_l = s1_site_ff.top_edge    ? col_l[1] : col_l[0];
      up_c = s1_site_ff.top_edge    ? col_c[1] : col_c[0];
      up_r = s1_site_ff.top_edge    ? col_r[1] : col_r[0];
      dn_l = s1_site_ff.bottom_edge ? col_l[1] : col_l[2];
      dn_c = s1_site_ff.bottom_edge ? col_c[1] : col_c[2];
      dn_r = s1_site_ff.bottom_edge ? col_r[1] : col_r[2];

      horiz_sum = SUM_BITS'(col_l[1]) + SUM_BITS'(col_r[1]);
      vert_sum  = SUM_BITS'(up_c) + SUM_BITS'(dn_c);
      cross_sum = horiz_sum + vert_sum;
      diag_sum  = SUM_BITS'(up_l) + SUM_BITS'(up_r) + SUM_BITS'(dn_l) + SUM_BITS'(dn_r);

      cross_avg = cross_sum[SUM_BITS-1:2];
      diag_avg  = diag_sum[SUM_BITS-1:2];
      horiz_avg = horiz_sum[SAMPLE_BITS:1];
      vert_avg  = vert_sum[SAMPLE_BITS:1];

      case ({s1_site_ff.odd_row, s1_site_ff.odd_col})
         2'b00: begin
            red_c = col_c[1]; green_c = cross_avg; blue_c = diag_avg;
         end
         2'b01: begin
            red_c = horiz_avg; green_c = col_c[1]; blue_c = vert_avg;
         end
         2'b10: begin
            red_c = vert_avg; green_c = col_c[1]; blue_c = horiz_avg;
         end
         default: begin
            red_c = diag_avg; green_c = cross_avg; blue_c = col_c[1];
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_site_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         in_column_ff    <= '0;
         in_row_ff       <= '0;
         out_column_ff   <= '0;
         out_row_ff      <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         win_ff[0]       <= '0;
         win_ff[1]       <= '0;
         win_ff[2]       <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         in_column_ff    <= in_column_in;
         in_row_ff       <= in_row_in;
         out_column_ff   <= out_column_in;
         out_row_ff      <= out_row_in;
         s1_valid_ff     <= s1_valid_in;
         fwd_ff          <= fwd_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (s1_go) begin
            win_ff[0] <= win_in[0];
            win_ff[1] <= win_in[1];
            win_ff[2] <= win_in[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pass) begin
         s1_site_ff   <= site;
         s1_sample_ff <= frame_done ? '0 : req_tdata;
         s1_col_ff    <= in_column_ff;
         fwd_near_ff  <= s1_sample_ff;
         fwd_far_ff   <= near_eff;
      end
      if (s1_go && s1_site_ff.emit) begin
         red_ff       <= red_c;
         green_ff     <= green_c;
         blue_ff      <= blue_c;
         row_end_ff   <= s1_site_ff.row_end;
         frame_end_ff <= s1_site_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {blue_ff, green_ff, red_ff};
   assign rsp_tlast  = row_end_ff;
   assign rsp_tuser  = frame_end_ff;

   // ---------------- assertions ----------------
   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without row end");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      WIDTH_BITS'(in_column_ff) < w_eff)
      else $error("input column beyond frame width");

   a_fwd_needs_beat: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("forward flag set with empty window stage");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      pass && site.emit && site.frame_end |=>
         in_column_ff == '0 && in_row_ff == '0 && out_column_ff == '0 && out_row_ff == '0)
      else $error("counters not cleared after frame end");

   a_stall_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |-> !req_tready)
      else $error("intake open while window stage is blocked");

endmodule
`default_nettype wire
